// ===== rtl/rtcep_pkg.sv =====
// rtcep_pkg: shared constants, payload structs and calendar helper functions
// for the rtc register snapshot to epoch seconds block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtcep_pkg;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTURY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT   = 1'b1;

    localparam logic [11:0] PIVOT_RESET = 12'd2023;

    // status register b and hour byte bit positions
    localparam int unsigned STB_BINARY_BIT = 2;
    localparam int unsigned STB_H24_BIT    = 1;
    localparam int unsigned HOUR_PM_BIT    = 7;

    // calendar constants
    localparam logic [14:0] EPOCH_YEAR    = 15'd1970;
    localparam logic [14:0] MAX_YEAR      = 15'd9999;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    // 365 * 1970 + leap days in years 1..1969 + 1 for the one-based day
    localparam logic [22:0] DAYS_BIAS     = 23'd719528;
    // floor(p / 100) == (p * PIVOT_RECIP) >> PIVOT_SHIFT for any 12-bit p
    localparam logic [12:0] PIVOT_RECIP   = 13'd5243;
    localparam int unsigned PIVOT_SHIFT   = 19;

    // field widths
    localparam int unsigned EPOCH_W = 38;
    localparam int unsigned DAYS_W  = 22;
    localparam int unsigned TOD_W   = 17;

    typedef struct packed {
        logic [7:0] raw_seconds;
        logic [7:0] raw_minutes;
        logic [7:0] raw_hours;
        logic [7:0] raw_day;
        logic [7:0] raw_month;
        logic [7:0] raw_year;
        logic [7:0] raw_century;
        logic [7:0] status_b;
    } t_snap;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
        logic [13:0]       full_year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
        logic              invalid;
    } t_calc;

    // bcd byte to value, passthrough in binary mode
    function automatic logic [7:0] bcd_dec(input logic [7:0] b, input logic bin);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return bin ? b : ((hi << 3) + (hi << 1) + {4'd0, b[3:0]});
    endfunction

    // days in month, non-leap
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the first of month m, non-leap
    function automatic logic [8:0] month_cum(input logic [3:0] m);
        logic [8:0] cum;
        unique case (m)
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rtcep_if.sv =====
// rtcep_snap_if and rtcep_res_if: valid/ready channels for register snapshots
// and decoded results; depends on rtcep_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rtcep_snap_if import rtcep_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] raw_seconds;
    logic [7:0] raw_minutes;
    logic [7:0] raw_hours;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
    logic [7:0] raw_century;
    logic [7:0] status_b;

    modport source (
        output valid, raw_seconds, raw_minutes, raw_hours, raw_day,
               raw_month, raw_year, raw_century, status_b,
        input  ready
    );
    modport sink (
        input  valid, raw_seconds, raw_minutes, raw_hours, raw_day,
               raw_month, raw_year, raw_century, status_b,
        output ready
    );
endinterface

interface rtcep_res_if import rtcep_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EPOCH_W-1:0] epoch_seconds;
    logic [13:0]        full_year;
    logic [3:0]         month_out;
    logic [4:0]         day_out;
    logic [4:0]         hour_out;
    logic [5:0]         minute_out;
    logic [5:0]         second_out;
    logic               invalid;

    modport source (
        output valid, epoch_seconds, full_year, month_out, day_out,
               hour_out, minute_out, second_out, invalid,
        input  ready
    );
    modport sink (
        input  valid, epoch_seconds, full_year, month_out, day_out,
               hour_out, minute_out, second_out, invalid,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/rtcep_calc.sv =====
// rtcep_calc: bcd decode, hour conversion, year forming, range checks and
// day count / time of day for one snapshot; depends on rtcep_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtcep_calc import rtcep_pkg::*; (
    input  var t_snap       i_snap,
    input  wire logic       i_century_present,
    input  wire logic [11:0] i_pivot_year,
    output var t_calc       o_calc
);

    logic        bin, h24, pm;
    logic [7:0]  sec, min, hr_raw, day, mon, yy, cen;
    logic [7:0]  hr;
    logic [24:0] pq_prod;
    logic [5:0]  pq;
    logic [11:0] prem_w;
    logic [6:0]  prem;
    logic        bump;
    logic [7:0]  cent;
    logic [14:0] year;
    logic        leap;
    logic [4:0]  mlen;
    logic [6:0]  c7, y7, lx;
    logic [22:0] days_sum;
    logic [16:0] tod;
    logic        bad_ms, bad_hr, bad_cen, bad_year, bad_mon, bad_day, bad;

    // field decode
    always_comb begin
        bin    = i_snap.status_b[STB_BINARY_BIT];
        h24    = i_snap.status_b[STB_H24_BIT];
        pm     = i_snap.raw_hours[HOUR_PM_BIT];
        sec    = bcd_dec(i_snap.raw_seconds, bin);
        min    = bcd_dec(i_snap.raw_minutes, bin);
        hr_raw = bcd_dec({1'b0, i_snap.raw_hours[6:0]}, bin);
        day    = bcd_dec(i_snap.raw_day, bin);
        mon    = bcd_dec(i_snap.raw_month, bin);
        yy     = bcd_dec(i_snap.raw_year, bin);
        cen    = bcd_dec(i_snap.raw_century, bin);
    end

    // 12/24 hour handling
    always_comb begin
        hr     = hr_raw;
        bad_hr = 1'b0;
        if (h24) begin
            bad_hr = pm || (hr_raw > 8'd23);
        end else if ((hr_raw < 8'd1) || (hr_raw > 8'd12)) begin
            bad_hr = 1'b1;
        end else if (pm) begin
            if (hr_raw != 8'd12) begin
                hr = hr_raw + 8'd12;
            end
        end else if (hr_raw == 8'd12) begin
            hr = 8'd0;
        end
    end

    // full year: century byte, or pivot century with wrap into the next one
    always_comb begin
        pq_prod = 25'(i_pivot_year) * 25'(PIVOT_RECIP);
        pq      = pq_prod[24:PIVOT_SHIFT];
        prem_w  = i_pivot_year - 12'(12'(pq) * 12'd100);
        prem    = prem_w[6:0];
        bump    = yy < {1'b0, prem};
        cent    = i_century_present ? cen : (8'(pq) + 8'(bump));
        year    = 15'(15'(cent) * 15'd100) + 15'(yy);
    end

    // calendar range checks; year mod 100 is yy and year / 100 is cent
    always_comb begin
        bad_ms   = (sec > 8'd59) || (min > 8'd59) || (yy > 8'd99);
        bad_cen  = i_century_present && (cen > 8'd99);
        bad_year = (year < EPOCH_YEAR) || (year > MAX_YEAR);
        leap     = (yy[1:0] == 2'b00) && ((yy != 8'd0) || (cent[1:0] == 2'b00));
        mlen     = month_len(mon[3:0]);
        if ((mon == 8'd2) && leap) begin
            mlen = 5'd29;
        end
        bad_mon  = (mon < 8'd1) || (mon > 8'd12);
        bad_day  = !bad_mon && ((day < 8'd1) || (day > {3'd0, mlen}));
        bad      = bad_ms || bad_hr || bad_cen || bad_year || bad_mon || bad_day;
    end

    // day count since the epoch and seconds into the day, valid items only
    always_comb begin
        c7 = cent[6:0];
        y7 = yy[6:0];
        if (y7 == 7'd0) begin
            lx = (c7 - 7'd1) >> 2;
        end else begin
            lx = ((y7 - 7'd1) >> 2) + (c7 >> 2);
        end
        days_sum = 23'(23'(c7) * 23'd36524) + 23'(23'(y7) * 23'd365) + 23'(lx)
                 + 23'(month_cum(mon[3:0])) + 23'((mon > 8'd2) && leap)
                 + 23'(day[4:0]) - DAYS_BIAS;
        tod      = 17'(17'(hr[4:0]) * SECS_PER_HOUR) + 17'(17'(min[5:0]) * 17'd60)
                 + 17'(sec[5:0]);
    end

    // result fields
    always_comb begin
        o_calc.days      = bad ? '0 : days_sum[DAYS_W-1:0];
        o_calc.tod       = bad ? '0 : tod;
        o_calc.full_year = (year > MAX_YEAR) ? MAX_YEAR[13:0] : year[13:0];
        o_calc.month     = mon[3:0];
        o_calc.day       = day[4:0];
        o_calc.hour      = hr[4:0];
        o_calc.minute    = min[5:0];
        o_calc.second    = sec[5:0];
        o_calc.invalid   = bad;
    end

endmodule

`default_nettype wire

// ===== rtl/rtc_registers_to_epoch_seconds_top.sv =====
// Converts one snapshot of CMOS RTC clock bytes plus status register B into
// decoded calendar fields, an invalid flag and seconds since 1970-01-01.
// The block is a three-stage pipeline: input register, decode/day-count
// stage, and a result register holding days * 86400 + time of day. One
// snapshot is taken every cycle unless the pipe is held. Each stage
// advances when it is empty or the stage after it moves, so a stalled
// result holds the pipe only once all three stages are full. The user
// must write configuration (century_present, pivot_year) through the plain
// write port only while no transaction is in flight; the block does not
// enforce it. Depends on rtcep_pkg, rtcep_if and rtcep_calc.
`timescale 1ns / 1ps
`default_nettype none

module rtc_registers_to_epoch_seconds_top import rtcep_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rtcep_snap_if.sink                 i_snap,
    rtcep_res_if.source                o_res
);

    logic        r_century_present;
    logic [11:0] r_pivot_year;

    logic        r_v1, r_v2, r_v3;
    t_snap       r_snap;
    t_calc       r_calc;
    t_calc       n_calc;
    t_calc       r_res;
    logic [EPOCH_W-1:0] r_epoch;
    logic [EPOCH_W-1:0] n_epoch;
    logic        rdy1, rdy2, rdy3;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_century_present <= 1'b0;
            r_pivot_year      <= PIVOT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTURY: r_century_present <= i_cfg_wdata[0];
                CFG_PIVOT:   r_pivot_year      <= i_cfg_wdata;
                default:     ;
            endcase
        end
    end

    // stage advance
    assign rdy3 = !r_v3 || o_res.ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_snap.ready = rdy1;

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_snap.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_snap.valid) begin
            r_snap.raw_seconds <= i_snap.raw_seconds;
            r_snap.raw_minutes <= i_snap.raw_minutes;
            r_snap.raw_hours   <= i_snap.raw_hours;
            r_snap.raw_day     <= i_snap.raw_day;
            r_snap.raw_month   <= i_snap.raw_month;
            r_snap.raw_year    <= i_snap.raw_year;
            r_snap.raw_century <= i_snap.raw_century;
            r_snap.status_b    <= i_snap.status_b;
        end
    end

    // decode and day count
    rtcep_calc u_calc (
        .i_snap            (r_snap),
        .i_century_present (r_century_present),
        .i_pivot_year      (r_pivot_year),
        .o_calc            (n_calc)
    );

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_calc <= n_calc;
        end
    end

    // seconds since the epoch, below 2^38 for any valid date
    assign n_epoch = EPOCH_W'(EPOCH_W'(r_calc.days) * EPOCH_W'(SECS_PER_DAY))
                   + EPOCH_W'(r_calc.tod);

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_res   <= r_calc;
            r_epoch <= n_epoch;
        end
    end

    // result channel
    assign o_res.valid         = r_v3;
    assign o_res.epoch_seconds = r_epoch;
    assign o_res.full_year     = r_res.full_year;
    assign o_res.month_out     = r_res.month;
    assign o_res.day_out       = r_res.day;
    assign o_res.hour_out      = r_res.hour;
    assign o_res.minute_out    = r_res.minute;
    assign o_res.second_out    = r_res.second;
    assign o_res.invalid       = r_res.invalid;

endmodule

`default_nettype wire

// ===== rtl/rtcep_checker.sv =====
// rtcep_checker: port-level assertions for the epoch seconds block, bound
// to rtc_registers_to_epoch_seconds_top; depends on rtcep_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtcep_checker import rtcep_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [EPOCH_W-1:0] i_epoch_seconds,
    input wire logic [13:0]        i_full_year,
    input wire logic [3:0]         i_month_out,
    input wire logic [4:0]         i_hour_out,
    input wire logic [5:0]         i_minute_out,
    input wire logic [5:0]         i_second_out,
    input wire logic               i_invalid
);

    // no result is offered in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // an invalid result carries zero seconds
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_invalid) |-> (i_epoch_seconds == '0))
        else $error("invalid result with nonzero seconds");

    // a valid result has calendar-range fields
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_invalid) |->
            ((i_month_out >= 4'd1) && (i_month_out <= 4'd12) && (i_hour_out <= 5'd23)
             && (i_minute_out <= 6'd59) && (i_second_out <= 6'd59)
             && (i_full_year >= 14'd1970)))
        else $error("valid result with out-of-range field");

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind rtc_registers_to_epoch_seconds_top rtcep_checker u_rtcep_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_epoch_seconds (o_res.epoch_seconds),
    .i_full_year     (o_res.full_year),
    .i_month_out     (o_res.month_out),
    .i_hour_out      (o_res.hour_out),
    .i_minute_out    (o_res.minute_out),
    .i_second_out    (o_res.second_out),
    .i_invalid       (o_res.invalid)
);

`default_nettype wire
